[rtl/stack_calculator_core_top_defines.svh]
// assertion macros used by the stack calculator top module
`ifndef STACK_CALCULATOR_CORE_TOP_DEFINES_SVH
`define STACK_CALCULATOR_CORE_TOP_DEFINES_SVH

// same-cycle implication, checked outside reset
`define SCC_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked outside reset
`define SCC_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[rtl/scc_pkg.sv]
// types and constants of the stack calculator
package scc_pkg;

    // stream field widths
    localparam int CMD_W       = 4;
    localparam int VALUE_W     = 32;
    localparam int STATUS_W    = 2;
    localparam int DEPTH_OUT_W = 9;
    localparam int IN_TDATA_W  = 40;
    localparam int OUT_TDATA_W = 48;

    // operation codes
    typedef enum logic [CMD_W-1:0] {
        CMD_PUSH  = 4'd0,
        CMD_ADD   = 4'd1,
        CMD_SUB   = 4'd2,
        CMD_MUL   = 4'd3,
        CMD_DIV   = 4'd4,
        CMD_DUP   = 4'd5,
        CMD_DROP  = 4'd6,
        CMD_SWAP  = 4'd7,
        CMD_OVER  = 4'd8,
        CMD_ROT   = 4'd9,
        CMD_PRINT = 4'd10,
        CMD_CLEAR = 4'd11
    } cmd_t;

    // result status codes
    typedef enum logic [STATUS_W-1:0] {
        ST_OK    = 2'd0,
        ST_OVER  = 2'd1,
        ST_UNDER = 2'd2,
        ST_DIVZ  = 2'd3
    } status_t;

    // movement of the cell chain in one cycle
    typedef enum logic [1:0] {
        SH_HOLD,
        SH_DOWN,
        SH_UP
    } shift_t;

    // per-cell control
    typedef struct packed {
        shift_t mode;
        logic   load;
    } cell_ctl_t;

    // request to the serial multiply/divide unit
    typedef struct packed {
        logic start;
        logic div;
    } arith_req_t;

    // sequencer states
    typedef enum logic {
        FSM_IDLE,
        FSM_ARITH
    } fsm_t;

endpackage

[rtl/scc_cell.sv]
// one stack cell: holds one entry and trades it with its neighbours
module scc_cell #(
    parameter int WORD_BITS = 32
) (
    input  logic                    clk,
    input  scc_pkg::cell_ctl_t      ctl,
    input  logic [WORD_BITS-1:0]    load_val,
    input  logic [WORD_BITS-1:0]    above,
    input  logic [WORD_BITS-1:0]    below,
    output logic [WORD_BITS-1:0]    word
);
    import scc_pkg::*;

    logic [WORD_BITS-1:0] word_reg;
    logic [WORD_BITS-1:0] word_next;

    // select the entry for the next cycle
    always_comb
    begin
        case (ctl.mode)
            SH_DOWN: word_next = above;
            SH_UP:   word_next = below;
            default: word_next = word_reg;
        endcase
        if (ctl.load)
        begin
            word_next = load_val;
        end
    end

    // entry storage, no reset needed
    always_ff @(posedge clk)
    begin
        word_reg <= word_next;
    end

    assign word = word_reg;

endmodule

[rtl/scc_arith.sv]
// serial multiply and divide unit, one bit per cycle
module scc_arith #(
    parameter int WORD_BITS = 32
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  scc_pkg::arith_req_t     req,
    input  logic [WORD_BITS-1:0]    a,
    input  logic [WORD_BITS-1:0]    b,
    output logic                    done,
    output logic [WORD_BITS-1:0]    result
);
    import scc_pkg::*;

    localparam int CNT_W = $clog2(WORD_BITS);
    localparam logic [CNT_W-1:0] LAST = CNT_W'(WORD_BITS - 1);

    logic                 busy_reg, busy_next;
    logic                 done_reg, done_next;
    logic [CNT_W-1:0]     cnt_reg, cnt_next;
    logic                 div_reg, div_next;
    logic                 neg_reg, neg_next;
    logic [WORD_BITS-1:0] x_reg, x_next;
    logic [WORD_BITS-1:0] y_reg, y_next;
    logic [WORD_BITS-1:0] acc_reg, acc_next;

    logic [WORD_BITS:0]   rem_sh;
    logic [WORD_BITS:0]   diff;
    logic [WORD_BITS-1:0] a_mag;
    logic [WORD_BITS-1:0] b_mag;

    // operand magnitudes for division
    assign a_mag = a[WORD_BITS-1] ? (~a + 1'b1) : a;
    assign b_mag = b[WORD_BITS-1] ? (~b + 1'b1) : b;

    // restoring division trial subtract
    assign rem_sh = {acc_reg, x_reg[WORD_BITS-1]};
    assign diff   = rem_sh - {1'b0, y_reg};

    // step logic
    always_comb
    begin
        busy_next = busy_reg;
        done_next = done_reg;
        cnt_next  = cnt_reg;
        div_next  = div_reg;
        neg_next  = neg_reg;
        x_next    = x_reg;
        y_next    = y_reg;
        acc_next  = acc_reg;
        if (req.start)
        begin
            busy_next = 1'b1;
            done_next = 1'b0;
            cnt_next  = '0;
            div_next  = req.div;
            neg_next  = a[WORD_BITS-1] ^ b[WORD_BITS-1];
            x_next    = req.div ? a_mag : a;
            y_next    = req.div ? b_mag : b;
            acc_next  = '0;
        end
        else if (busy_reg)
        begin
            if (div_reg)
            begin
                if (!diff[WORD_BITS])
                begin
                    acc_next = diff[WORD_BITS-1:0];
                end
                else
                begin
                    acc_next = rem_sh[WORD_BITS-1:0];
                end
                x_next = {x_reg[WORD_BITS-2:0], ~diff[WORD_BITS]};
            end
            else
            begin
                if (y_reg[0])
                begin
                    acc_next = acc_reg + x_reg;
                end
                x_next = {x_reg[WORD_BITS-2:0], 1'b0};
                y_next = {1'b0, y_reg[WORD_BITS-1:1]};
            end
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == LAST)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        div_reg <= div_next;
        neg_reg <= neg_next;
        x_reg   <= x_next;
        y_reg   <= y_next;
        acc_reg <= acc_next;
    end

    // quotient gets its sign back, product is the low word
    assign done   = done_reg;
    assign result = div_reg ? (neg_reg ? (~x_reg + 1'b1) : x_reg) : acc_reg;

endmodule

[rtl/stack_calculator_core_top.sv]
// stack calculator: sequencer, stack cell chain and serial arithmetic unit
// a transaction is held in the input register, and its result is registered in the output register
// mul and div also wait for the one-bit-per-cycle arith unit and block new input until it is done
// throughput: one transaction per cycle for stack ops while the output is not stalled
// reset: rst_n asynchronous active low, empties the stack; entry contents are not cleared
`include "stack_calculator_core_top_defines.svh"

module stack_calculator_core_top #(
    parameter int STACK_ENTRIES = 256,
    parameter int WORD_BITS     = 32
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               s_tvalid,
    output logic                               s_tready,
    input  logic [scc_pkg::IN_TDATA_W-1:0]     s_tdata,  // command[3:0], value[35:4], zero[39:36]
    output logic                               m_tvalid,
    input  logic                               m_tready,
    output logic [scc_pkg::OUT_TDATA_W-1:0]    m_tdata   // status[1:0], print_valid[2],
                                                         // printed_value[34:3], depth[43:35],
                                                         // zero[47:44]
);
    import scc_pkg::*;

    localparam int DEPTH_W = $clog2(STACK_ENTRIES + 1);
    localparam logic [DEPTH_W-1:0] FULL = DEPTH_W'(STACK_ENTRIES);
    localparam int PAD_W = OUT_TDATA_W - DEPTH_OUT_W - VALUE_W - 1 - STATUS_W;

    // input holding register
    logic                   in_full_reg, in_full_next;
    logic [CMD_W-1:0]       cmd_reg, cmd_next;
    logic [VALUE_W-1:0]     value_reg, value_next;

    fsm_t                   state_reg, state_next;
    logic [DEPTH_W-1:0]     depth_reg, depth_next;

    // output register
    logic                   m_valid_reg, m_valid_next;
    logic [OUT_TDATA_W-1:0] m_data_reg, m_data_next;

    logic                   s_fire;
    logic                   out_free;
    logic                   commit;
    logic                   is_long;
    logic [1:0]             need;
    logic                   grows;
    status_t                status;
    arith_req_t             arith_req;
    logic                   arith_done;
    logic [WORD_BITS-1:0]   arith_result;

    logic [WORD_BITS-1:0]   word_q [STACK_ENTRIES];
    logic [WORD_BITS-1:0]   t0, t1, t2;
    logic [WORD_BITS-1:0]   lit;
    logic [WORD_BITS+VALUE_W-1:0] lit_ext;
    logic [WORD_BITS+VALUE_W-1:0] pval_ext;
    logic [DEPTH_W+DEPTH_OUT_W-1:0] depth_ext;

    shift_t                 shift_mode;
    logic                   load_en  [3];
    logic [WORD_BITS-1:0]   load_val [3];
    logic                   print_valid;
    logic [VALUE_W-1:0]     printed_value;

    assign t0 = word_q[0];
    assign t1 = word_q[1];
    assign t2 = word_q[2];

    // push literal, sign-extended or cut to the word width
    assign lit_ext  = {{WORD_BITS{value_reg[VALUE_W-1]}}, value_reg};
    assign lit      = lit_ext[WORD_BITS-1:0];
    assign pval_ext = {{VALUE_W{1'b0}}, t0};

    assign s_fire   = s_tvalid && s_tready;
    assign out_free = !m_valid_reg || m_tready;
    assign s_tready = !in_full_reg || commit;

    // operand count and growth per command
    always_comb
    begin
        need  = 2'd0;
        grows = 1'b0;
        case (cmd_reg)
            CMD_PUSH:  grows = 1'b1;
            CMD_ADD, CMD_SUB, CMD_MUL, CMD_DIV, CMD_SWAP: need = 2'd2;
            CMD_DUP:   begin need = 2'd1; grows = 1'b1; end
            CMD_DROP, CMD_PRINT: need = 2'd1;
            CMD_OVER:  begin need = 2'd2; grows = 1'b1; end
            CMD_ROT:   need = 2'd3;
            default:   need = 2'd0;
        endcase
    end

    // status of the held command
    always_comb
    begin
        if (depth_reg < DEPTH_W'(need))
        begin
            status = ST_UNDER;
        end
        else if (grows && depth_reg == FULL)
        begin
            status = ST_OVER;
        end
        else if (cmd_reg == CMD_DIV && t0 == '0)
        begin
            status = ST_DIVZ;
        end
        else
        begin
            status = ST_OK;
        end
    end

    assign is_long = (cmd_reg == CMD_MUL || cmd_reg == CMD_DIV) && status == ST_OK;

    // sequencer next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            FSM_IDLE:
            begin
                if (in_full_reg && is_long)
                begin
                    state_next = FSM_ARITH;
                end
            end
            FSM_ARITH:
            begin
                if (arith_done && out_free)
                begin
                    state_next = FSM_IDLE;
                end
            end
            default: state_next = FSM_IDLE;
        endcase
    end

    // sequencer outputs
    always_comb
    begin
        commit          = 1'b0;
        arith_req.start = 1'b0;
        arith_req.div   = (cmd_reg == CMD_DIV);
        case (state_reg)
            FSM_IDLE:
            begin
                arith_req.start = in_full_reg && is_long;
                commit          = in_full_reg && !is_long && out_free;
            end
            FSM_ARITH:
            begin
                commit = in_full_reg && arith_done && out_free;
            end
            default:
            begin
                commit = 1'b0;
            end
        endcase
    end

    // stack update program for the committed command
    always_comb
    begin
        shift_mode    = SH_HOLD;
        depth_next    = depth_reg;
        print_valid   = 1'b0;
        printed_value = '0;
        for (int i = 0; i < 3; i++)
        begin
            load_en[i]  = 1'b0;
            load_val[i] = t0;
        end
        if (commit && status == ST_OK)
        begin
            case (cmd_reg)
                CMD_PUSH:
                begin
                    shift_mode  = SH_DOWN;
                    load_en[0]  = 1'b1;
                    load_val[0] = lit;
                    depth_next  = depth_reg + 1'b1;
                end
                CMD_ADD, CMD_SUB, CMD_MUL, CMD_DIV:
                begin
                    shift_mode = SH_UP;
                    load_en[0] = 1'b1;
                    if (cmd_reg == CMD_ADD)
                    begin
                        load_val[0] = t1 + t0;
                    end
                    else if (cmd_reg == CMD_SUB)
                    begin
                        load_val[0] = t1 - t0;
                    end
                    else
                    begin
                        load_val[0] = arith_result;
                    end
                    depth_next = depth_reg - 1'b1;
                end
                CMD_DUP:
                begin
                    shift_mode  = SH_DOWN;
                    load_en[0]  = 1'b1;
                    depth_next  = depth_reg + 1'b1;
                end
                CMD_DROP:
                begin
                    shift_mode = SH_UP;
                    depth_next = depth_reg - 1'b1;
                end
                CMD_SWAP:
                begin
                    load_en[0]  = 1'b1;
                    load_val[0] = t1;
                    load_en[1]  = 1'b1;
                    load_val[1] = t0;
                end
                CMD_OVER:
                begin
                    shift_mode  = SH_DOWN;
                    load_en[0]  = 1'b1;
                    load_val[0] = t1;
                    depth_next  = depth_reg + 1'b1;
                end
                CMD_ROT:
                begin
                    load_en[0]  = 1'b1;
                    load_val[0] = t2;
                    load_en[1]  = 1'b1;
                    load_val[1] = t0;
                    load_en[2]  = 1'b1;
                    load_val[2] = t1;
                end
                CMD_PRINT:
                begin
                    shift_mode    = SH_UP;
                    print_valid   = 1'b1;
                    printed_value = pval_ext[VALUE_W-1:0];
                    depth_next    = depth_reg - 1'b1;
                end
                CMD_CLEAR:
                begin
                    depth_next = '0;
                end
                default:
                begin
                    shift_mode = SH_HOLD;
                end
            endcase
        end
    end

    assign depth_ext = {{DEPTH_OUT_W{1'b0}}, depth_next};

    // input and output register next values
    always_comb
    begin
        in_full_next = in_full_reg;
        cmd_next     = cmd_reg;
        value_next   = value_reg;
        if (commit)
        begin
            in_full_next = 1'b0;
        end
        if (s_fire)
        begin
            in_full_next = 1'b1;
            cmd_next     = s_tdata[CMD_W-1:0];
            value_next   = s_tdata[CMD_W+VALUE_W-1:CMD_W];
        end
        m_valid_next = m_valid_reg;
        m_data_next  = m_data_reg;
        if (m_tready)
        begin
            m_valid_next = 1'b0;
        end
        if (commit)
        begin
            m_valid_next = 1'b1;
            m_data_next  = {{PAD_W{1'b0}}, depth_ext[DEPTH_OUT_W-1:0], printed_value,
                            print_valid, status};
        end
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_full_reg <= 1'b0;
            state_reg   <= FSM_IDLE;
            depth_reg   <= '0;
            m_valid_reg <= 1'b0;
        end
        else
        begin
            in_full_reg <= in_full_next;
            state_reg   <= state_next;
            depth_reg   <= depth_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        cmd_reg    <= cmd_next;
        value_reg  <= value_next;
        m_data_reg <= m_data_next;
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

    // serial multiply and divide on the two top entries
    scc_arith #(
        .WORD_BITS (WORD_BITS)
    ) u_arith (
        .clk    (clk),
        .rst_n  (rst_n),
        .req    (arith_req),
        .a      (t1),
        .b      (t0),
        .done   (arith_done),
        .result (arith_result)
    );

    // chain of stack cells, top of stack in cell 0
    for (genvar i = 0; i < STACK_ENTRIES; i++)
    begin : g_cell
        cell_ctl_t            cctl;
        logic [WORD_BITS-1:0] above;
        logic [WORD_BITS-1:0] below;
        logic [WORD_BITS-1:0] cload;

        assign cctl.mode = shift_mode;

        if (i == 0)
        begin : g_first
            assign above = '0;
        end
        else
        begin : g_inner
            assign above = word_q[i-1];
        end

        if (i == STACK_ENTRIES - 1)
        begin : g_last
            assign below = '0;
        end
        else
        begin : g_upper
            assign below = word_q[i+1];
        end

        if (i < 3)
        begin : g_top
            assign cctl.load = load_en[i];
            assign cload     = load_val[i];
        end
        else
        begin : g_deep
            assign cctl.load = 1'b0;
            assign cload     = '0;
        end

        scc_cell #(
            .WORD_BITS (WORD_BITS)
        ) u_cell (
            .clk      (clk),
            .ctl      (cctl),
            .load_val (cload),
            .above    (above),
            .below    (below),
            .word     (word_q[i])
        );
    end

    // checks
    `SCC_ASSERT_IMP(a_depth_range, clk, rst_n, 1'b1, depth_reg <= FULL, "stack depth out of range")
    `SCC_ASSERT_IMP(a_arith_has_item, clk, rst_n, state_reg == FSM_ARITH, in_full_reg, "arith state without a held transaction")
    `SCC_ASSERT_NXT(a_error_keeps_depth, clk, rst_n, commit && status != ST_OK, depth_reg == $past(depth_reg), "failed command changed depth")
    `SCC_ASSERT_IMP(a_print_ok, clk, rst_n, m_valid_reg && m_data_reg[STATUS_W], status_t'(m_data_reg[STATUS_W-1:0]) == ST_OK, "print result with error status")

endmodule

[sim/stack_calculator_checker.sv]
// result checker for the stack calculator: predicts every result and compares it with the block
`timescale 1ns / 1ps

module stack_calculator_checker #(
    parameter int STACK_ENTRIES = 256
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            s_tvalid,
    input  logic                            s_tready,
    input  logic [scc_pkg::IN_TDATA_W-1:0]  s_tdata,  // command[3:0], value[35:4], zero[39:36]
    input  logic                            m_tvalid,
    input  logic                            m_tready,
    input  logic [scc_pkg::OUT_TDATA_W-1:0] m_tdata,  // status[1:0], print_valid[2],
                                                      // printed_value[34:3], depth[43:35],
                                                      // zero[47:44]
    output int                              mismatch_count,
    output int                              results_outstanding
);

    import scc_pkg::*;

    // one result of the calculator
    typedef struct packed {
        status_t              status;
        logic                 print_valid;
        logic [VALUE_W-1:0]   printed_value;
        logic [DEPTH_OUT_W-1:0] depth;
    } calc_result_t;

    // shadow copy of the stack, keyed by position from the bottom
    logic [VALUE_W-1:0] stack_words [int unsigned];
    int unsigned        stack_count = 0;

    // results predicted but not yet seen on the output
    calc_result_t       predicted_results [$];
    int                 error_total = 0;

    // word at a given distance below the top of the stack
    function automatic logic [VALUE_W-1:0] word_below_top(input int unsigned from_top);
        return stack_words[stack_count - 1 - from_top];
    endfunction

    // truncating signed division, minimum by minus one wraps
    function automatic logic [VALUE_W-1:0] divide_toward_zero(input logic [VALUE_W-1:0] num,
                                                             input logic [VALUE_W-1:0] den);
        logic [VALUE_W-1:0] mag_num;
        logic [VALUE_W-1:0] mag_den;
        logic [VALUE_W-1:0] quotient;
        mag_num  = num[VALUE_W-1] ? -num : num;
        mag_den  = den[VALUE_W-1] ? -den : den;
        quotient = mag_num / mag_den;
        return (num[VALUE_W-1] ^ den[VALUE_W-1]) ? -quotient : quotient;
    endfunction

    // apply one operation to the shadow stack and work out its result
    task automatic apply_stack_op(input logic [CMD_W-1:0] code,
                                  input logic [VALUE_W-1:0] word,
                                  output calc_result_t res);
        int unsigned        need;
        logic               grows;
        logic [VALUE_W-1:0] a;
        logic [VALUE_W-1:0] b;
        logic [VALUE_W-1:0] c;
        res.status        = ST_OK;
        res.print_valid   = 1'b0;
        res.printed_value = '0;
        need  = 0;
        grows = 1'b0;

        // entries needed and whether the stack grows
        case (code)
            CMD_PUSH:                            grows = 1'b1;
            CMD_ADD, CMD_SUB, CMD_MUL, CMD_DIV,
            CMD_SWAP:                            need = 2;
            CMD_DUP:
            begin
                need  = 1;
                grows = 1'b1;
            end
            CMD_DROP, CMD_PRINT:                 need = 1;
            CMD_OVER:
            begin
                need  = 2;
                grows = 1'b1;
            end
            CMD_ROT:                             need = 3;
            default:                             need = 0;
        endcase

        // underflow takes precedence over overflow
        if (stack_count < need)
        begin
            res.status = ST_UNDER;
        end
        else if (grows && stack_count >= STACK_ENTRIES)
        begin
            res.status = ST_OVER;
        end
        else
        begin
            case (code)
                CMD_PUSH:
                begin
                    stack_words[stack_count] = word;
                    stack_count++;
                end
                CMD_ADD, CMD_SUB, CMD_MUL, CMD_DIV:
                begin
                    b = word_below_top(0);
                    a = word_below_top(1);
                    if (code == CMD_DIV && b == '0)
                    begin
                        res.status = ST_DIVZ;
                    end
                    else
                    begin
                        case (code)
                            CMD_ADD: c = a + b;
                            CMD_SUB: c = a - b;
                            CMD_MUL: c = a * b;
                            default: c = divide_toward_zero(a, b);
                        endcase
                        stack_count--;
                        stack_words[stack_count - 1] = c;
                    end
                end
                CMD_DUP:
                begin
                    a = word_below_top(0);
                    stack_words[stack_count] = a;
                    stack_count++;
                end
                CMD_DROP:
                begin
                    stack_count--;
                end
                CMD_SWAP:
                begin
                    b = word_below_top(0);
                    a = word_below_top(1);
                    stack_words[stack_count - 1] = a;
                    stack_words[stack_count - 2] = b;
                end
                CMD_OVER:
                begin
                    a = word_below_top(1);
                    stack_words[stack_count] = a;
                    stack_count++;
                end
                CMD_ROT:
                begin
                    c = word_below_top(0);
                    b = word_below_top(1);
                    a = word_below_top(2);
                    stack_words[stack_count - 3] = b;
                    stack_words[stack_count - 2] = c;
                    stack_words[stack_count - 1] = a;
                end
                CMD_PRINT:
                begin
                    res.print_valid   = 1'b1;
                    res.printed_value = word_below_top(0);
                    stack_count--;
                end
                CMD_CLEAR:
                begin
                    stack_count = 0;
                end
                default:
                begin
                end
            endcase
        end
        res.depth = stack_count[DEPTH_OUT_W-1:0];
    endtask

    // watch both channels on every rising edge
    always @(posedge clk or negedge rst_n)
    begin : watch_channels
        calc_result_t oldest;
        calc_result_t fresh;
        if (!rst_n)
        begin
            stack_count = 0;
            predicted_results.delete();
            results_outstanding <= 0;
        end
        else
        begin
            // output transaction against the oldest prediction
            if (m_tvalid && m_tready)
            begin
                if (predicted_results.size() == 0)
                begin
                    error_total++;
                    $error("result transaction with no prediction pending: %h", m_tdata);
                end
                else
                begin
                    oldest = predicted_results.pop_front();
                    if (m_tdata[1:0] != oldest.status)
                    begin
                        error_total++;
                        $error("status: expected %0d, actual %0d", oldest.status, m_tdata[1:0]);
                    end
                    if (m_tdata[2] != oldest.print_valid)
                    begin
                        error_total++;
                        $error("print_valid: expected %0d, actual %0d",
                               oldest.print_valid, m_tdata[2]);
                    end
                    if (m_tdata[34:3] != oldest.printed_value)
                    begin
                        error_total++;
                        $error("printed_value: expected %0d, actual %0d",
                               $signed(oldest.printed_value), $signed(m_tdata[34:3]));
                    end
                    if (m_tdata[43:35] != oldest.depth)
                    begin
                        error_total++;
                        $error("depth: expected %0d, actual %0d", oldest.depth, m_tdata[43:35]);
                    end
                end
            end

            // input transaction updates the shadow stack
            if (s_tvalid && s_tready)
            begin
                apply_stack_op(s_tdata[3:0], s_tdata[35:4], fresh);
                predicted_results.push_back(fresh);
            end
            results_outstanding <= predicted_results.size();
        end
        mismatch_count <= error_total;
    end

endmodule

[sim/tb_stack_calculator_core_top.sv]
// testbench top for the stack calculator: clock, reset, stimulus, back-pressure and verdict
`timescale 1ns / 1ps

module tb_stack_calculator_core_top;

    import scc_pkg::*;

    localparam int CLK_PERIOD    = 12;
    localparam int STACK_ENTRIES = 256;
    localparam int WORD_BITS     = 32;
    localparam int ITEM_TARGET   = 550;
    localparam int BURST_AFTER   = 150;
    localparam int PHASE_LEN     = 40;
    localparam int CYCLE_LIMIT   = 400000;
    localparam int DRAIN_CYCLES  = 40;

    // codes outside the operation set
    localparam logic [CMD_W-1:0] CMD_UNUSED_LO = 4'd12;
    localparam logic [CMD_W-1:0] CMD_UNUSED_HI = 4'd15;

    // word extremes
    localparam logic [VALUE_W-1:0] WORD_MAX  = 32'h7FFF_FFFF;
    localparam logic [VALUE_W-1:0] WORD_MIN  = 32'h8000_0000;
    localparam logic [VALUE_W-1:0] WORD_ONES = 32'hFFFF_FFFF;

    // idling phases, rotated every PHASE_LEN transactions
    typedef enum logic [1:0] {
        PH_NO_IDLE,
        PH_SEND_IDLE,
        PH_RECV_STALL,
        PH_BOTH_IDLE
    } idle_phase_t;

    logic                   clk;
    logic                   rst_n;
    logic                   s_tvalid;
    logic                   s_tready;
    logic [IN_TDATA_W-1:0]  s_tdata;
    logic                   m_tvalid;
    logic                   m_tready;
    logic [OUT_TDATA_W-1:0] m_tdata;

    int                     mismatch_count;
    int                     results_outstanding;
    int                     items_sent     = 0;
    int                     send_idle_pct  = 0;
    int                     recv_stall_pct = 0;
    int                     cycle_count    = 0;
    logic                   burst_done     = 1'b0;

    stack_calculator_core_top #(
        .STACK_ENTRIES(STACK_ENTRIES),
        .WORD_BITS    (WORD_BITS)
    ) DUT (
        .clk     (clk),
        .rst_n   (rst_n),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata (s_tdata),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata (m_tdata)
    );

    stack_calculator_checker #(
        .STACK_ENTRIES(STACK_ENTRIES)
    ) result_check (
        .clk                (clk),
        .rst_n              (rst_n),
        .s_tvalid           (s_tvalid),
        .s_tready           (s_tready),
        .s_tdata            (s_tdata),
        .m_tvalid           (m_tvalid),
        .m_tready           (m_tready),
        .m_tdata            (m_tdata),
        .mismatch_count     (mismatch_count),
        .results_outstanding(results_outstanding)
    );

    // clock
    initial
    begin
        clk = 1'b0;
        forever #(CLK_PERIOD / 2) clk = ~clk;
    end

    // run limit
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("tb_stack_calculator_core_top: done, errors");
            $finish;
        end
    end

    // receiver back-pressure, changed at the falling edge
    initial
    begin
        m_tready = 1'b0;
        forever
        begin
            @(negedge clk);
            m_tready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // random word, biased towards the extremes and small magnitudes
    function automatic logic [VALUE_W-1:0] rand_word();
        case ($urandom_range(9))
            0:       return '0;
            1:       return WORD_ONES;
            2:       return WORD_MIN;
            3:       return WORD_MAX;
            4:       return $urandom_range(16);
            5:       return -$urandom_range(16);
            default: return $urandom();
        endcase
    endfunction

    // one input transaction, with random idle cycles before it
    task automatic send_item(input logic [CMD_W-1:0] code, input logic [VALUE_W-1:0] word);
        case (idle_phase_t'((items_sent / PHASE_LEN) % 4))
            PH_NO_IDLE:
            begin
                send_idle_pct  = 0;
                recv_stall_pct = 0;
            end
            PH_SEND_IDLE:
            begin
                send_idle_pct  = 51;
                recv_stall_pct = 0;
            end
            PH_RECV_STALL:
            begin
                send_idle_pct  = 0;
                recv_stall_pct = 51;
            end
            default:
            begin
                send_idle_pct  = 16;
                recv_stall_pct = 16;
            end
        endcase
        while ($urandom_range(99) < send_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {{(IN_TDATA_W - VALUE_W - CMD_W){1'b0}}, word, code};
        @(posedge clk);
        while (!s_tready) @(posedge clk);
        @(negedge clk);
        items_sent++;
    endtask

    // one short well-formed sequence, or noise
    task automatic run_sequence();
        logic [CMD_W-1:0] code;
        int               reps;
        case ($urandom_range(9))
            // binary arithmetic on two fresh operands
            0, 1, 2, 3:
            begin
                send_item(CMD_PUSH, rand_word());
                send_item(CMD_PUSH, rand_word());
                case ($urandom_range(3))
                    0:       code = CMD_ADD;
                    1:       code = CMD_SUB;
                    2:       code = CMD_MUL;
                    default: code = CMD_DIV;
                endcase
                send_item(code, $urandom());
                if ($urandom_range(1) == 1)
                    send_item(CMD_PRINT, $urandom());
            end
            // stack shuffles on three fresh entries
            4, 5:
            begin
                send_item(CMD_PUSH, rand_word());
                send_item(CMD_PUSH, rand_word());
                send_item(CMD_PUSH, rand_word());
                reps = $urandom_range(1, 2);
                repeat (reps)
                begin
                    case ($urandom_range(3))
                        0:       code = CMD_DUP;
                        1:       code = CMD_SWAP;
                        2:       code = CMD_OVER;
                        default: code = CMD_ROT;
                    endcase
                    send_item(code, $urandom());
                end
                send_item(CMD_PRINT, $urandom());
            end
            // pop whatever is there
            6:
            begin
                send_item($urandom_range(1) ? CMD_PRINT : CMD_DROP, $urandom());
            end
            7:
            begin
                send_item(CMD_CLEAR, $urandom());
            end
            // any code, any value
            default:
            begin
                reps = $urandom_range(1, 4);
                repeat (reps)
                begin
                    code = CMD_W'($urandom_range(15));
                    send_item(code, $urandom());
                end
            end
        endcase
    endtask

    // fill the stack to the top, try to grow it, then empty it
    task automatic fill_stack_burst();
        send_item(CMD_CLEAR, $urandom());
        repeat (STACK_ENTRIES) send_item(CMD_PUSH, rand_word());
        send_item(CMD_PUSH, rand_word());
        send_item(CMD_DUP, $urandom());
        send_item(CMD_OVER, $urandom());
        send_item(CMD_ROT, $urandom());
        send_item(CMD_PRINT, $urandom());
        send_item(CMD_OVER, $urandom());
        send_item(CMD_SWAP, $urandom());
        send_item(CMD_CLEAR, $urandom());
    endtask

    // reset, directed transactions, random sequences and the verdict
    initial
    begin : stimulus
        rst_n    = 1'b0;
        s_tvalid = 1'b0;
        s_tdata  = '0;
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // directed: empty stack, wrap-around, division corners, every operation
        send_item(CMD_PRINT, WORD_ONES);
        send_item(CMD_ADD, '0);
        send_item(CMD_PUSH, WORD_MAX);
        send_item(CMD_PUSH, 32'd1);
        send_item(CMD_ADD, '0);
        send_item(CMD_PUSH, WORD_ONES);
        send_item(CMD_DIV, '0);
        send_item(CMD_PUSH, '0);
        send_item(CMD_DIV, '0);
        send_item(CMD_DROP, '0);
        send_item(CMD_PUSH, -32'sd7);
        send_item(CMD_PUSH, 32'd2);
        send_item(CMD_DIV, '0);
        send_item(CMD_SUB, '0);
        send_item(CMD_PUSH, WORD_MIN);
        send_item(CMD_MUL, '0);
        send_item(CMD_DUP, '0);
        send_item(CMD_OVER, '0);
        send_item(CMD_SWAP, '0);
        send_item(CMD_ROT, '0);
        send_item(CMD_PRINT, '0);
        send_item(CMD_UNUSED_HI, WORD_ONES);
        send_item(CMD_UNUSED_LO, WORD_MIN);
        send_item(CMD_CLEAR, WORD_ONES);
        send_item(CMD_ROT, '0);

        // random sequences, with one trip to a full stack
        while (items_sent < ITEM_TARGET)
        begin
            if (!burst_done && items_sent >= BURST_AFTER)
            begin
                fill_stack_burst();
                burst_done = 1'b1;
            end
            else
            begin
                run_sequence();
            end
        end
        s_tvalid <= 1'b0;

        // drain outstanding results
        while (results_outstanding != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatch_count == 0)
            $display("tb_stack_calculator_core_top: done, clean");
        else
            $display("tb_stack_calculator_core_top: done, errors");
        $finish;
    end

endmodule
